@@ rtl/lscd_pkg.sv @@
package lscd_pkg;

  localparam int NUM_SLOTS_DEF = 32;
  localparam int NUM_IDS_DEF   = 256;

  // Widths that hold the largest slot number and ID that the parameters allow.
  localparam int SLOT_W_MAX  = 8;
  localparam int ID_W_MAX    = 12;
  localparam int STAMP_W     = 64;
  localparam int CNT_W       = 32;
  localparam int CFG_W       = 6;
  localparam int EXPERT_W    = 8;
  localparam int EXPERT_SPAN = 256;
  localparam int SLOT_OUT_W  = 5;
  localparam int VICTIM_W    = 8;

  localparam logic [CFG_W-1:0] CFG_ACTIVE_RST = 6'd32;

  typedef logic [SLOT_W_MAX-1:0] slot_t;
  typedef logic [ID_W_MAX-1:0]   id_t;
  typedef logic [STAMP_W-1:0]    stamp_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Search state handed from one slot cell to the next.
  typedef struct packed {
    logic   go;
    logic   hit;
    slot_t  hit_slot;
    logic   free;
    slot_t  free_slot;
    logic   old_ok;
    stamp_t old_stamp;
    slot_t  old_slot;
    id_t    old_owner;
  } scan_t;

  // Broadcast update of one slot.
  typedef struct packed {
    logic   en;
    slot_t  slot;
    id_t    id;
    stamp_t stamp;
  } wr_t;

endpackage

@@ rtl/lru_slot_cache_directory_unit.sv @@
// An accepted input beat passes the start register, the scan register of each slot
//   cell, the result register and the output register on its way to the result beat.
// Requests are taken only while idle; the wave steps through the slot cells one per cycle.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n low, synchronous) empties every slot, clears stamp and counters,
//   and sets the active slot count to 32.
module lru_slot_cache_directory_unit #(
  parameter int NUM_SLOTS = lscd_pkg::NUM_SLOTS_DEF,
  parameter int NUM_IDS   = lscd_pkg::NUM_IDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lscd_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lscd_pkg::EXPERT_W-1:0]   in_expert_id,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lscd_pkg::SLOT_OUT_W-1:0] out_slot_index,
  output logic                            out_miss,
  output logic                            out_evicted,
  output logic [lscd_pkg::VICTIM_W-1:0]   out_victim_id,
  output lscd_pkg::cnt_t                  out_hits_total,
  output lscd_pkg::cnt_t                  out_misses_total,
  output lscd_pkg::cnt_t                  out_evictions_total
);

  localparam int ID_W = $clog2(NUM_IDS);
  localparam int AW   = ($clog2(NUM_SLOTS + 1) > lscd_pkg::CFG_W) ?
                        $clog2(NUM_SLOTS + 1) : lscd_pkg::CFG_W;

  logic [lscd_pkg::CFG_W-1:0] active_r;
  logic [AW-1:0]              act_ext;
  logic [AW-1:0]              act_n;
  lscd_pkg::scan_t            chain [NUM_SLOTS+1];
  lscd_pkg::wr_t              wr;
  logic [ID_W-1:0]            req_id;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= lscd_pkg::CFG_ACTIVE_RST;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  // A count of zero acts as one slot; a count above the slot total acts as all.
  always_comb begin
    act_ext = AW'(active_r);
    if (act_ext == '0) begin
      act_n = AW'(1);
    end else if (act_ext > AW'(NUM_SLOTS)) begin
      act_n = AW'(NUM_SLOTS);
    end else begin
      act_n = act_ext;
    end
  end

  lscd_ctrl #(
    .NUM_IDS(NUM_IDS)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_expert_id        (in_expert_id),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_slot_index      (out_slot_index),
    .out_miss            (out_miss),
    .out_evicted         (out_evicted),
    .out_victim_id       (out_victim_id),
    .out_hits_total      (out_hits_total),
    .out_misses_total    (out_misses_total),
    .out_evictions_total (out_evictions_total),
    .scan_start_o        (chain[0]),
    .scan_end_i          (chain[NUM_SLOTS]),
    .wr_o                (wr),
    .req_id_o            (req_id)
  );

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    lscd_cell #(
      .IDX     (i),
      .NUM_IDS (NUM_IDS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .active_i (AW'(i) < act_n),
      .id_i     (req_id),
      .wr_i     (wr),
      .scan_i   (chain[i]),
      .scan_o   (chain[i+1])
    );
  end

endmodule

@@ rtl/lscd_cell.sv @@
module lscd_cell #(
  parameter int IDX     = 0,
  parameter int NUM_IDS = lscd_pkg::NUM_IDS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    active_i,
  input  logic [$clog2(NUM_IDS)-1:0] id_i,
  input  lscd_pkg::wr_t           wr_i,
  input  lscd_pkg::scan_t         scan_i,
  output lscd_pkg::scan_t         scan_o
);

  localparam int ID_W = $clog2(NUM_IDS);
  localparam lscd_pkg::slot_t MY_SLOT = lscd_pkg::slot_t'(IDX);

  logic [ID_W-1:0]  owner_r;
  lscd_pkg::stamp_t stamp_r;
  logic             used_r;
  lscd_pkg::scan_t  scan_r;
  lscd_pkg::scan_t  scan_nxt;

  always_comb begin
    scan_nxt = scan_i;
    // Owners of used slots are unique, so at most one cell reports a hit.
    if (used_r && (owner_r == id_i)) begin
      scan_nxt.hit      = 1'b1;
      scan_nxt.hit_slot = MY_SLOT;
    end
    if (active_i && !used_r && !scan_i.free) begin
      scan_nxt.free      = 1'b1;
      scan_nxt.free_slot = MY_SLOT;
    end
    // A strict compare keeps the lowest-numbered slot among equal stamps.
    if (active_i && (!scan_i.old_ok || (stamp_r < scan_i.old_stamp))) begin
      scan_nxt.old_ok    = 1'b1;
      scan_nxt.old_stamp = stamp_r;
      scan_nxt.old_slot  = MY_SLOT;
      scan_nxt.old_owner = lscd_pkg::id_t'(owner_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (wr_i.en && (wr_i.slot == MY_SLOT)) begin
      used_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.en && (wr_i.slot == MY_SLOT)) begin
      owner_r <= wr_i.id[ID_W-1:0];
      stamp_r <= wr_i.stamp;
    end
  end

  assign scan_o = scan_r;

endmodule

@@ rtl/lscd_ctrl.sv @@
module lscd_ctrl #(
  parameter int NUM_IDS = lscd_pkg::NUM_IDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lscd_pkg::EXPERT_W-1:0]       in_expert_id,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lscd_pkg::SLOT_OUT_W-1:0]     out_slot_index,
  output logic                                out_miss,
  output logic                                out_evicted,
  output logic [lscd_pkg::VICTIM_W-1:0]       out_victim_id,
  output lscd_pkg::cnt_t                      out_hits_total,
  output lscd_pkg::cnt_t                      out_misses_total,
  output lscd_pkg::cnt_t                      out_evictions_total,
  output lscd_pkg::scan_t                     scan_start_o,
  input  lscd_pkg::scan_t                     scan_end_i,
  output lscd_pkg::wr_t                       wr_o,
  output logic [$clog2(NUM_IDS)-1:0]          req_id_o
);

  localparam int ID_W = $clog2(NUM_IDS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic             start_r;
  logic [ID_W-1:0]  req_id_r;
  lscd_pkg::scan_t  res_r;
  lscd_pkg::stamp_t stamp_r, stamp_nxt;
  lscd_pkg::cnt_t   hit_cnt_r, hit_cnt_nxt;
  lscd_pkg::cnt_t   miss_cnt_r, miss_cnt_nxt;
  lscd_pkg::cnt_t   evict_cnt_r, evict_cnt_nxt;
  logic             out_valid_r;
  logic             accept;
  logic             out_free;
  logic             finish;
  lscd_pkg::slot_t  slot_sel;
  logic             do_evict;
  logic [ID_W-1:0]  id_map [lscd_pkg::EXPERT_SPAN];

  // Folding of the incoming ID into the ID range, as a constant table.
  for (genvar v = 0; v < lscd_pkg::EXPERT_SPAN; v++) begin : g_map
    assign id_map[v] = ID_W'(v % NUM_IDS);
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign finish   = (state_r == ST_DONE) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_end_i.go) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    do_evict = 1'b0;
    if (res_r.hit) begin
      slot_sel = res_r.hit_slot;
    end else if (res_r.free) begin
      slot_sel = res_r.free_slot;
    end else begin
      slot_sel = res_r.old_slot;
      do_evict = 1'b1;
    end
  end

  assign stamp_nxt     = stamp_r + lscd_pkg::stamp_t'(1);
  assign hit_cnt_nxt   = (res_r.hit && (hit_cnt_r != '1)) ?
                         hit_cnt_r + lscd_pkg::cnt_t'(1) : hit_cnt_r;
  assign miss_cnt_nxt  = (!res_r.hit && (miss_cnt_r != '1)) ?
                         miss_cnt_r + lscd_pkg::cnt_t'(1) : miss_cnt_r;
  assign evict_cnt_nxt = (!res_r.hit && do_evict && (evict_cnt_r != '1)) ?
                         evict_cnt_r + lscd_pkg::cnt_t'(1) : evict_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      stamp_r     <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
      if (finish) begin
        out_valid_r <= 1'b1;
        stamp_r     <= stamp_nxt;
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        evict_cnt_r <= evict_cnt_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_id_r <= id_map[in_expert_id];
    end
    if ((state_r == ST_SCAN) && scan_end_i.go) begin
      res_r <= scan_end_i;
    end
    if (finish) begin
      out_slot_index      <= slot_sel[lscd_pkg::SLOT_OUT_W-1:0];
      out_miss            <= !res_r.hit;
      out_evicted         <= do_evict;
      out_victim_id       <= do_evict ? res_r.old_owner[lscd_pkg::VICTIM_W-1:0] : '0;
      out_hits_total      <= hit_cnt_nxt;
      out_misses_total    <= miss_cnt_nxt;
      out_evictions_total <= evict_cnt_nxt;
    end
  end

  always_comb begin
    scan_start_o    = '0;
    scan_start_o.go = start_r;
  end

  // A hit rewrites the same owner, so one update form serves every case.
  always_comb begin
    wr_o.en    = finish;
    wr_o.slot  = slot_sel;
    wr_o.id    = lscd_pkg::id_t'(req_id_r);
    wr_o.stamp = stamp_nxt;
  end

  assign out_valid = out_valid_r;
  assign req_id_o  = req_id_r;

endmodule
